/* rtl/ldps_pkg.sv */
// shared types, constants and microcode program for the line point solver
package ldps_pkg;

    localparam int COEFF_BITS_DEF = 32;
    localparam int IN_W           = 32;
    localparam int OUT_W          = 64;
    localparam int UPC_W          = 4;

    localparam logic signed [OUT_W-1:0] COORD_LIMIT = 64'sd5000000000000000000;

    // datapath operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_DIV_R = 4'd1;
    localparam logic [3:0] OP_STEP  = 4'd2;
    localparam logic [3:0] OP_MUL_S = 4'd3;
    localparam logic [3:0] OP_UPD_S = 4'd4;
    localparam logic [3:0] OP_MUL_T = 4'd5;
    localparam logic [3:0] OP_UPD_T = 4'd6;
    localparam logic [3:0] OP_DIV_C = 4'd7;
    localparam logic [3:0] OP_SET_C = 4'd8;
    localparam logic [3:0] OP_MUL_X = 4'd9;
    localparam logic [3:0] OP_MUL_Y = 4'd10;
    localparam logic [3:0] OP_DONE  = 4'd11;
    localparam logic [3:0] OP_FAIL  = 4'd12;

    // sequencer conditions
    localparam logic [2:0] COND_NEXT  = 3'd0;
    localparam logic [2:0] COND_R1Z   = 3'd1;
    localparam logic [2:0] COND_R0Z   = 3'd2;
    localparam logic [2:0] COND_REMNZ = 3'd3;
    localparam logic [2:0] COND_WAIT  = 3'd4;
    localparam logic [2:0] COND_JUMP  = 3'd5;
    localparam logic [2:0] COND_END   = 3'd6;

    // program addresses
    localparam logic [UPC_W-1:0] PC_LOOP   = 4'd0;
    localparam logic [UPC_W-1:0] PC_FINISH = 4'd8;
    localparam logic [UPC_W-1:0] PC_FAIL   = 4'd15;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
    } ctrl_t;

    typedef struct packed {
        logic r0_zero;
        logic r1_zero;
        logic rem_nz;
        logic div_busy;
    } stat_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_NEXT, target: PC_LOOP};
        case (pc)
            4'd0:  w = '{op: OP_NOP,   cond: COND_R1Z,   target: PC_FINISH};
            4'd1:  w = '{op: OP_DIV_R, cond: COND_NEXT,  target: PC_LOOP};
            4'd2:  w = '{op: OP_NOP,   cond: COND_WAIT,  target: PC_LOOP};
            4'd3:  w = '{op: OP_STEP,  cond: COND_NEXT,  target: PC_LOOP};
            4'd4:  w = '{op: OP_MUL_S, cond: COND_NEXT,  target: PC_LOOP};
            4'd5:  w = '{op: OP_UPD_S, cond: COND_NEXT,  target: PC_LOOP};
            4'd6:  w = '{op: OP_MUL_T, cond: COND_NEXT,  target: PC_LOOP};
            4'd7:  w = '{op: OP_UPD_T, cond: COND_JUMP,  target: PC_LOOP};
            4'd8:  w = '{op: OP_NOP,   cond: COND_R0Z,   target: PC_FAIL};
            4'd9:  w = '{op: OP_DIV_C, cond: COND_NEXT,  target: PC_LOOP};
            4'd10: w = '{op: OP_NOP,   cond: COND_WAIT,  target: PC_LOOP};
            4'd11: w = '{op: OP_SET_C, cond: COND_REMNZ, target: PC_FAIL};
            4'd12: w = '{op: OP_MUL_X, cond: COND_NEXT,  target: PC_LOOP};
            4'd13: w = '{op: OP_MUL_Y, cond: COND_NEXT,  target: PC_LOOP};
            4'd14: w = '{op: OP_DONE,  cond: COND_END,   target: PC_LOOP};
            4'd15: w = '{op: OP_FAIL,  cond: COND_END,   target: PC_LOOP};
            default: w = '{op: OP_NOP, cond: COND_END,   target: PC_LOOP};
        endcase
        return w;
    endfunction

endpackage

/* rtl/ldps_div.sv */
// radix-2 restoring divider with truncating signed quotient and remainder
module ldps_div #(
    parameter int DW = 33
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic signed [DW-1:0] divisor,
    output logic                 busy,
    output logic signed [DW-1:0] quotient,
    output logic signed [DW-1:0] remainder
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg;
    logic          neg_q_reg, neg_r_reg;
    logic [DW-1:0] nmag, dmag;
    logic [DW:0]   shifted, diff;

    assign nmag = dividend[DW-1] ? DW'(0) - dividend : dividend;
    assign dmag = divisor[DW-1]  ? DW'(0) - divisor  : divisor;

    // one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, den_reg};
        if (!diff[DW])
        begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DW-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= nmag;
            den_reg   <= dmag;
            neg_q_reg <= dividend[DW-1] ^ divisor[DW-1];
            neg_r_reg <= dividend[DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = neg_q_reg ? DW'(0) - quo_reg : quo_reg;
    assign remainder = neg_r_reg ? DW'(0) - rem_reg : rem_reg;

endmodule

/* rtl/ldps_seq.sv */
// microcode sequencer: step counter, program rom and conditional jumps
module ldps_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ldps_pkg::stat_t stat,
    output ldps_pkg::ctrl_t ctrl,
    output logic            busy
);
    import ldps_pkg::*;

    logic             busy_reg, busy_next;
    logic [UPC_W-1:0] pc_reg, pc_next;
    ucode_t           word;
    logic [UPC_W-1:0] pc_inc;

    assign word   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + UPC_W'(1);

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = PC_LOOP;
            end
        end
        else
        begin
            case (word.cond)
                COND_NEXT:  pc_next = pc_inc;
                COND_R1Z:   pc_next = stat.r1_zero ? word.target : pc_inc;
                COND_R0Z:   pc_next = stat.r0_zero ? word.target : pc_inc;
                COND_REMNZ: pc_next = stat.rem_nz ? word.target : pc_inc;
                COND_WAIT:  pc_next = stat.div_busy ? pc_reg : pc_inc;
                COND_JUMP:  pc_next = word.target;
                COND_END:   busy_next = 1'b0;
                default:    busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_LOOP;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.load = start & ~busy_reg;
    assign ctrl.op   = busy_reg ? word.op : OP_NOP;
    assign busy      = busy_reg;

endmodule

/* rtl/ldps_dp.sv */
// datapath: remainder, bezout and coefficient registers, shared divider and multiplier
module ldps_dp #(
    parameter int COEFF_BITS = ldps_pkg::COEFF_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ldps_pkg::ctrl_t                ctrl,
    input  logic signed [ldps_pkg::IN_W-1:0]  coeff_a,
    input  logic signed [ldps_pkg::IN_W-1:0]  coeff_b,
    input  logic signed [ldps_pkg::IN_W-1:0]  coeff_c,
    output ldps_pkg::stat_t                stat,
    output logic                           done,
    output logic                           found,
    output logic signed [ldps_pkg::OUT_W-1:0] point_x,
    output logic signed [ldps_pkg::OUT_W-1:0] point_y
);
    import ldps_pkg::*;

    localparam int DW = COEFF_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] r0_reg, r1_reg, s0_reg, s1_reg, t0_reg, t1_reg;
    logic signed [DW-1:0] c_reg, q_reg;
    logic signed [PW-1:0] prod_reg, px_reg, py_reg;
    logic                 done_reg, found_reg;
    logic signed [OUT_W-1:0] x_reg, y_reg;

    logic signed [DW-1:0] a_ext, b_ext, c_ext;
    logic signed [DW-1:0] div_n, div_d, div_q, div_r;
    logic                 div_start, div_busy;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [OUT_W-1:0] x64, y64;
    logic                 x_ok, y_ok;

    assign a_ext = DW'(signed'(coeff_a[COEFF_BITS-1:0]));
    assign b_ext = DW'(signed'(coeff_b[COEFF_BITS-1:0]));
    assign c_ext = DW'(signed'(coeff_c[COEFF_BITS-1:0]));

    assign div_start = (ctrl.op == OP_DIV_R) || (ctrl.op == OP_DIV_C);
    assign div_n     = (ctrl.op == OP_DIV_C) ? c_reg : r0_reg;
    assign div_d     = (ctrl.op == OP_DIV_C) ? r0_reg : r1_reg;

    ldps_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // one shared multiplier, product always registered
    always_comb
    begin
        mul_a = q_reg;
        mul_b = s1_reg;
        case (ctrl.op)
            OP_MUL_T: mul_b = t1_reg;
            OP_MUL_X:
            begin
                mul_a = s0_reg;
                mul_b = c_reg;
            end
            OP_MUL_Y:
            begin
                mul_a = t0_reg;
                mul_b = c_reg;
            end
            default: mul_b = s1_reg;
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            r0_reg <= a_ext;
            r1_reg <= b_ext;
            s0_reg <= DW'(1);
            s1_reg <= '0;
            t0_reg <= '0;
            t1_reg <= DW'(1);
            c_reg  <= DW'(0) - c_ext;
        end
        else
        begin
            case (ctrl.op)
                OP_STEP:
                begin
                    q_reg  <= div_q;
                    r0_reg <= r1_reg;
                    r1_reg <= div_r;
                end
                OP_MUL_S, OP_MUL_T: prod_reg <= mul_p;
                OP_UPD_S:
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= s0_reg - prod_reg[DW-1:0];
                end
                OP_UPD_T:
                begin
                    t0_reg <= t1_reg;
                    t1_reg <= t0_reg - prod_reg[DW-1:0];
                end
                OP_SET_C: c_reg <= div_q;
                OP_MUL_X: px_reg <= mul_p;
                OP_MUL_Y: py_reg <= mul_p;
                default: ;
            endcase
        end
    end

    assign x64  = OUT_W'(px_reg);
    assign y64  = OUT_W'(py_reg);
    assign x_ok = (x64 >= -COORD_LIMIT) && (x64 <= COORD_LIMIT);
    assign y_ok = (y64 >= -COORD_LIMIT) && (y64 <= COORD_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            done_reg <= (ctrl.op == OP_DONE) || (ctrl.op == OP_FAIL);
            if (ctrl.op == OP_DONE && x_ok && y_ok)
            begin
                found_reg <= 1'b1;
                x_reg     <= x64;
                y_reg     <= y64;
            end
            else if (ctrl.op == OP_DONE || ctrl.op == OP_FAIL)
            begin
                found_reg <= 1'b0;
                x_reg     <= '0;
                y_reg     <= '0;
            end
        end
    end

    assign stat.r0_zero  = (r0_reg == '0);
    assign stat.r1_zero  = (r1_reg == '0);
    assign stat.rem_nz   = (div_r != '0);
    assign stat.div_busy = div_busy;

    assign done    = done_reg;
    assign found   = found_reg;
    assign point_x = x_reg;
    assign point_y = y_reg;

endmodule

/* rtl/linear_diophantine_point_solver_core.sv */
// top level: integer point on a*x + b*y + c = 0 by microcoded extended euclid
// each euclid step and the final divide wait on the shared radix-2 divider.
// one transaction at a time; busy is high until the result. the result shows on done
// for one cycle, the receiver cannot stall. reset clears the sequencer, divider control
// and result registers.
module linear_diophantine_point_solver_core #(
    parameter int COEFF_BITS = ldps_pkg::COEFF_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [ldps_pkg::IN_W-1:0]  coeff_a,
    input  logic signed [ldps_pkg::IN_W-1:0]  coeff_b,
    input  logic signed [ldps_pkg::IN_W-1:0]  coeff_c,
    output logic                              done,
    output logic                              found,
    output logic signed [ldps_pkg::OUT_W-1:0] point_x,
    output logic signed [ldps_pkg::OUT_W-1:0] point_y
);
    import ldps_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    ldps_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    ldps_dp #(
        .COEFF_BITS (COEFF_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .coeff_a (coeff_a),
        .coeff_b (coeff_b),
        .coeff_c (coeff_c),
        .stat    (stat),
        .done    (done),
        .found   (found),
        .point_x (point_x),
        .point_y (point_y)
    );

    // a result only follows a transaction in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in flight");

    // the transaction ends exactly when its result is shown
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (point_x == '0 && point_y == '0))
        else $error("no-solution result carries a nonzero point");

endmodule

/* dv/tb_linear_diophantine_point_solver_core.sv */
`timescale 1ns / 100ps
// self-checking testbench for the line point solver core
module tb_linear_diophantine_point_solver_core;
    import ldps_pkg::*;

    typedef struct packed {
        logic                    found;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } line_point_t;

    typedef struct packed {
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic signed [IN_W-1:0] c;
        logic                   typed;
        line_point_t            pt;
    } line_case_t;

    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 280;
    localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;

    localparam logic signed [IN_W-1:0] MIN_COEFF = 32'sh8000_0000;
    localparam logic signed [IN_W-1:0] MAX_COEFF = 32'sh7fff_ffff;

    localparam line_point_t NO_POINT = '{1'b0, 64'sd0, 64'sd0};

    // typed rows carry their expected point, the others go through the predictor
    localparam line_case_t DIRECTED [0:N_DIRECTED-1] = '{
        '{32'sd0, 32'sd0, 32'sd0, 1'b1, NO_POINT},
        '{32'sd0, 32'sd0, 32'sd7, 1'b1, NO_POINT},
        '{32'sd0, 32'sd0, MIN_COEFF, 1'b1, NO_POINT},
        '{32'sd1, 32'sd0, 32'sd0, 1'b1, '{1'b1, 64'sd0, 64'sd0}},
        '{32'sd1, 32'sd0, -32'sd5, 1'b1, '{1'b1, 64'sd5, 64'sd0}},
        '{32'sd0, 32'sd3, 32'sd6, 1'b1, '{1'b1, 64'sd0, -64'sd2}},
        '{32'sd2, 32'sd4, 32'sd1, 1'b1, NO_POINT},
        '{32'sd6, 32'sd9, 32'sd5, 1'b1, NO_POINT},
        '{32'sd12, 32'sd18, 32'sd0, 1'b1, '{1'b1, 64'sd0, 64'sd0}},
        '{32'sd4, 32'sd6, 32'sd3, 1'b1, NO_POINT},
        '{32'sd0, MIN_COEFF, MAX_COEFF, 1'b1, NO_POINT},
        '{MIN_COEFF, MIN_COEFF, MIN_COEFF, 1'b0, NO_POINT},
        '{MAX_COEFF, MAX_COEFF, MAX_COEFF, 1'b0, NO_POINT},
        '{MAX_COEFF, MIN_COEFF, MIN_COEFF, 1'b0, NO_POINT},
        '{MIN_COEFF, MAX_COEFF, MAX_COEFF, 1'b0, NO_POINT},
        '{32'sd2000000000, -32'sd2000000000, 32'sd2000000000, 1'b0, NO_POINT},
        '{-32'sd1, 32'sd0, MIN_COEFF, 1'b0, NO_POINT},
        '{32'sd0, -32'sd1, 32'sd5, 1'b0, NO_POINT},
        // consecutive fibonacci numbers give the longest euclid chain
        '{32'sd1836311903, 32'sd1134903170, -32'sd1, 1'b0, NO_POINT},
        '{32'sd1134903170, 32'sd1836311903, 32'sd7, 1'b0, NO_POINT},
        '{-32'sd7, 32'sd3, 32'sd1, 1'b0, NO_POINT},
        '{32'sd5, -32'sd5, 32'sd10, 1'b0, NO_POINT},
        '{32'sd0, MIN_COEFF, MIN_COEFF, 1'b0, NO_POINT}
    };

    logic                    clk     = 1'b0;
    logic                    rst_n   = 1'b0;
    logic                    start   = 1'b0;
    logic signed [IN_W-1:0]  coeff_a = '0;
    logic signed [IN_W-1:0]  coeff_b = '0;
    logic signed [IN_W-1:0]  coeff_c = '0;
    logic                    busy;
    logic                    done;
    logic                    found;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;

    line_point_t pending_points [$];
    line_point_t oldest_point;
    int          mismatch_cnt = 0;
    int          lines_sent   = 0;

    linear_diophantine_point_solver_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .coeff_a (coeff_a),
        .coeff_b (coeff_b),
        .coeff_c (coeff_c),
        .done    (done),
        .found   (found),
        .point_x (point_x),
        .point_y (point_y)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // integer point on a*x + b*y + c = 0, gcd and quotients keep the sign of truncation
    function automatic line_point_t solve_line(input logic signed [IN_W-1:0] ca,
                                               input logic signed [IN_W-1:0] cb,
                                               input logic signed [IN_W-1:0] cc);
        longint      a, b, c, p, q, r, g, u, v, t;
        longint      quo [0:63];
        int          depth;
        int          k;
        line_point_t res;
        res = NO_POINT;
        a = ca;
        b = cb;
        c = cc;
        c = -c;
        p = a;
        q = b;
        while (p != 0 && q != 0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        g = (p == 0) ? q : p;
        if (g == 0 || c % g != 0)
            return res;
        a = a / g;
        b = b / g;
        c = c / g;
        // walk down the euclid chain, then fold the quotients back up
        p = a;
        q = b;
        depth = 0;
        while (q != 0 && p != 0)
        begin
            quo[depth] = p / q;
            depth++;
            r = p % q;
            p = q;
            q = r;
        end
        if (q == 0)
        begin
            u = 1;
            v = 0;
        end
        else
        begin
            u = 0;
            v = 1;
        end
        for (k = depth - 1; k >= 0; k--)
        begin
            t = u;
            u = v;
            v = t - quo[k] * v;
        end
        u = u * c;
        v = v * c;
        if (u < -COORD_LIMIT || u > COORD_LIMIT || v < -COORD_LIMIT || v > COORD_LIMIT)
            return res;
        res.found = 1'b1;
        res.x     = u;
        res.y     = v;
        return res;
    endfunction

    function automatic logic signed [IN_W-1:0] corner_coeff();
        case ($urandom_range(5))
            0:       return MIN_COEFF;
            1:       return MAX_COEFF;
            2:       return 32'sd0;
            3:       return 32'sd1;
            4:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // offers one transaction, returns at the falling edge after it was taken
    task automatic send_line(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] b,
                             input logic signed [IN_W-1:0] c,
                             input logic                   typed,
                             input line_point_t            typed_pt);
        int idle_pct;
        idle_pct = (lines_sent * 3 < N_TOTAL) ? 38 :
                   (lines_sent * 3 < 2 * N_TOTAL) ? 76 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            start   <= 1'b0;
            coeff_a <= $urandom;
            coeff_b <= $urandom;
            coeff_c <= $urandom;
            @(negedge clk);
        end
        start   <= 1'b1;
        coeff_a <= a;
        coeff_b <= b;
        coeff_c <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_points.push_back(typed ? typed_pt : solve_line(a, b, c));
        lines_sent++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_points.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with no transaction pending: found=%0b x=%0d y=%0d",
                             $realtime, found, point_x, point_y);
            end
            else
            begin
                oldest_point = pending_points.pop_front();
                if (found !== oldest_point.found || point_x !== oldest_point.x ||
                    point_y !== oldest_point.y)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: mismatch exp found=%0b x=%0d y=%0d, got found=%0b x=%0d y=%0d",
                                 $realtime, oldest_point.found, oldest_point.x, oldest_point.y,
                                 found, point_x, point_y);
                end
            end
        end
    end

    initial
    begin
        longint                 g;
        logic signed [IN_W-1:0] ra, rb, rc;
        int                     i;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_line(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].c,
                      DIRECTED[i].typed, DIRECTED[i].pt);

        for (i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    ra = $urandom;
                    rb = $urandom;
                    rc = $urandom;
                end
                3, 4:
                begin
                    // shared factor, c divisible by it most of the time
                    g  = $urandom_range(30000, 1);
                    ra = IN_W'(g * (longint'($urandom_range(131070)) - 65535));
                    rb = IN_W'(g * (longint'($urandom_range(131070)) - 65535));
                    rc = IN_W'(g * (longint'($urandom_range(131070)) - 65535));
                    if (g > 1 && $urandom_range(2) == 0)
                        rc = rc + $urandom_range(32'(g - 1), 1);
                end
                5:
                begin
                    ra = IN_W'(longint'($urandom_range(40)) - 20);
                    rb = IN_W'(longint'($urandom_range(40)) - 20);
                    rc = IN_W'(longint'($urandom_range(40)) - 20);
                end
                6:
                begin
                    if ($urandom_range(1))
                    begin
                        ra = 0;
                        rb = $urandom;
                        rc = $urandom_range(1) ? -rb : $urandom;
                    end
                    else
                    begin
                        ra = $urandom;
                        rb = 0;
                        rc = $urandom_range(1) ? ra : $urandom;
                    end
                end
                7:
                begin
                    ra = corner_coeff();
                    rb = corner_coeff();
                    rc = corner_coeff();
                end
                default:
                begin
                    ra = IN_W'(longint'($urandom_range(32'd4000000000)) - 2000000000);
                    rb = IN_W'(longint'($urandom_range(32'd4000000000)) - 2000000000);
                    rc = IN_W'(longint'($urandom_range(32'd4000000000)) - 2000000000);
                end
            endcase
            send_line(ra, rb, rc, 1'b0, NO_POINT);
        end

        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (mismatch_cnt == 0 && pending_points.size() == 0)
            $display("** linear_diophantine_point_solver_core: PASSED **");
        else
            $display("** linear_diophantine_point_solver_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("** linear_diophantine_point_solver_core: FAILED **");
        $finish;
    end

endmodule
